// File: rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Types and constants for the pipelined 3x3 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int DW  = 32;          // entry width
  localparam int FB  = 16;          // fraction bits
  localparam int SH  = 2 * FB;      // numerator pre-shift
  localparam int PW  = 2 * DW;      // entry product
  localparam int CW  = 2 * DW + 1;  // cofactor, signed
  localparam int HW  = 2 * DW + 1;  // det partial product
  localparam int DTW = 3 * DW + 3;  // determinant, signed
  localparam int MW  = DTW;         // determinant magnitude
  localparam int RW  = MW + 1;      // divider remainder
  localparam int NW  = CW + SH;     // shifted numerator magnitude
  localparam int QB  = DW + 1;      // quotient bits kept
  localparam int XW  = (NW > RW) ? NW : RW;
  localparam int NST = QB + 9;      // pipeline registers, input to output

  // cofactor i = m[A]*m[B] - m[C]*m[D]
  localparam int COF_SEL [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // determinant from row 0 against cofactors 0, 3, 6
  localparam int DET_COF [3] = '{0, 3, 6};

  typedef struct packed {
    logic signed [DW-1:0] in_r0c0;
    logic signed [DW-1:0] in_r0c1;
    logic signed [DW-1:0] in_r0c2;
    logic signed [DW-1:0] in_r1c0;
    logic signed [DW-1:0] in_r1c1;
    logic signed [DW-1:0] in_r1c2;
    logic signed [DW-1:0] in_r2c0;
    logic signed [DW-1:0] in_r2c1;
    logic signed [DW-1:0] in_r2c2;
  } mi3_in_t;

  typedef struct packed {
    logic signed [DW-1:0] inv_r0c0;
    logic signed [DW-1:0] inv_r0c1;
    logic signed [DW-1:0] inv_r0c2;
    logic signed [DW-1:0] inv_r1c0;
    logic signed [DW-1:0] inv_r1c1;
    logic signed [DW-1:0] inv_r1c2;
    logic signed [DW-1:0] inv_r2c0;
    logic signed [DW-1:0] inv_r2c1;
    logic signed [DW-1:0] inv_r2c2;
    logic                 singular;
    logic                 overflow;
  } mi3_out_t;

endpackage

// File: rtl/matrix_inverse_3x3_unit.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_unit
// Pipeline of 42 register stages (8 arithmetic, 33 restoring-divider, one
// output register). Throughput: one item per cycle; each stage holds when
// the next is full and stalled, so bubbles collapse. Reset clears only the
// stage valid bits; data registers are free.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mi3_pkg::mi3_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mi3_pkg::mi3_out_t out_data
);
  import mi3_pkg::*;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;

  // stage 0: input matrix
  logic signed [DW-1:0]  m_in  [9];
  logic signed [DW-1:0]  a0_r  [9];
  // stage 1: products
  logic signed [PW-1:0]  pp_r  [9];
  logic signed [PW-1:0]  ps_r  [9];
  logic signed [DW-1:0]  a1_r  [3];
  // stage 2: cofactors
  logic signed [CW-1:0]  cof2_r [9];
  logic signed [DW-1:0]  a2_r  [3];
  // stage 3: det partial products
  logic signed [HW-1:0]  dl_r  [3];
  logic signed [HW-1:0]  dh_r  [3];
  logic signed [CW-1:0]  cof3_r [9];
  // stage 4: det terms
  logic signed [DTW-1:0] dt_r  [3];
  logic signed [CW-1:0]  cof4_r [9];
  // stage 5: determinant
  logic signed [DTW-1:0] det_r;
  logic signed [CW-1:0]  cof5_r [9];
  // stage 6: magnitudes and signs
  logic [CW-1:0]         cm_r  [9];
  logic                  neg6_r [9];
  logic [MW-1:0]         dm_r;
  logic                  zero6_r;
  // divider pipe: index 0 is the setup stage, index QB the last step
  logic [RW-1:0]         rem_r  [QB+1][9];
  logic [QB-1:0]         q_r    [QB+1][9];
  logic [QB-1:0]         nb_r   [QB+1][9];
  logic                  neg_r  [QB+1][9];
  logic                  big_r  [QB+1][9];
  logic [MW-1:0]         den_r  [QB+1];
  logic                  zero_r [QB+1];
  // output
  mi3_out_t              out_r;
  mi3_out_t              out_nxt;

  // stall chain: a stage loads when it is empty or its successor moves
  always_comb begin
    en[NST-1] = !vld_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NST-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_comb begin
    m_in[0] = in_data.in_r0c0;
    m_in[1] = in_data.in_r0c1;
    m_in[2] = in_data.in_r0c2;
    m_in[3] = in_data.in_r1c0;
    m_in[4] = in_data.in_r1c1;
    m_in[5] = in_data.in_r1c2;
    m_in[6] = in_data.in_r2c0;
    m_in[7] = in_data.in_r2c1;
    m_in[8] = in_data.in_r2c2;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a0_r <= m_in;
    end
    if (en[1]) begin
      for (int i = 0; i < 9; i++) begin
        pp_r[i] <= PW'(a0_r[COF_SEL[i][0]]) * PW'(a0_r[COF_SEL[i][1]]);
        ps_r[i] <= PW'(a0_r[COF_SEL[i][2]]) * PW'(a0_r[COF_SEL[i][3]]);
      end
      for (int j = 0; j < 3; j++) begin
        a1_r[j] <= a0_r[j];
      end
    end
    if (en[2]) begin
      for (int i = 0; i < 9; i++) begin
        cof2_r[i] <= CW'(pp_r[i]) - CW'(ps_r[i]);
      end
      a2_r <= a1_r;
    end
    if (en[3]) begin
      // cofactor split: low DW bits unsigned, upper part signed
      for (int j = 0; j < 3; j++) begin
        dl_r[j] <= HW'(a2_r[j]) * HW'($signed({1'b0, cof2_r[DET_COF[j]][DW-1:0]}));
        dh_r[j] <= HW'(a2_r[j]) * HW'($signed(cof2_r[DET_COF[j]][CW-1:DW]));
      end
      cof3_r <= cof2_r;
    end
    if (en[4]) begin
      for (int j = 0; j < 3; j++) begin
        dt_r[j] <= (DTW'(dh_r[j]) <<< DW) + DTW'(dl_r[j]);
      end
      cof4_r <= cof3_r;
    end
    if (en[5]) begin
      det_r  <= dt_r[0] + dt_r[1] + dt_r[2];
      cof5_r <= cof4_r;
    end
    if (en[6]) begin
      for (int i = 0; i < 9; i++) begin
        cm_r[i]   <= cof5_r[i][CW-1] ? CW'(-cof5_r[i]) : CW'(cof5_r[i]);
        neg6_r[i] <= cof5_r[i][CW-1] ^ det_r[DTW-1];
      end
      dm_r    <= det_r[DTW-1] ? MW'(-det_r) : MW'(det_r);
      zero6_r <= (det_r == '0);
    end
  end

  // divider setup: prefix of |c| << SH above the kept quotient bits
  always_ff @(posedge clk) begin
    logic [NW-1:0] num;
    logic [XW-1:0] hix;
    if (en[7]) begin
      for (int i = 0; i < 9; i++) begin
        num            = {cm_r[i], {SH{1'b0}}};
        hix            = XW'(num >> QB);
        rem_r[0][i]    <= hix[RW-1:0];
        big_r[0][i]    <= (hix >= XW'(dm_r));
        nb_r[0][i]     <= num[QB-1:0];
        q_r[0][i]      <= '0;
        neg_r[0][i]    <= neg6_r[i];
      end
      den_r[0]  <= dm_r;
      zero_r[0] <= zero6_r;
    end
  end

  // one quotient bit per stage
  for (genvar d = 0; d < QB; d++) begin : g_div
    always_ff @(posedge clk) begin
      logic [RW-1:0] r2;
      logic          ge;
      if (en[8+d]) begin
        for (int i = 0; i < 9; i++) begin
          r2 = {rem_r[d][i][MW-1:0], nb_r[d][i][QB-1]};
          ge = (r2 >= {1'b0, den_r[d]});
          rem_r[d+1][i] <= ge ? (r2 - {1'b0, den_r[d]}) : r2;
          q_r[d+1][i]   <= {q_r[d][i][QB-2:0], ge};
          nb_r[d+1][i]  <= {nb_r[d][i][QB-2:0], 1'b0};
          neg_r[d+1][i] <= neg_r[d][i];
          big_r[d+1][i] <= big_r[d][i];
        end
        den_r[d+1]  <= den_r[d];
        zero_r[d+1] <= zero_r[d];
      end
    end
  end

  // saturation and sign
  always_comb begin
    logic signed [DW-1:0] inv [9];
    logic                 ovf;
    logic [QB-1:0]        q;
    ovf = 1'b0;
    for (int i = 0; i < 9; i++) begin
      q = q_r[QB][i];
      if (zero_r[QB]) begin
        inv[i] = '0;
      end else if (!neg_r[QB][i]) begin
        if (big_r[QB][i] || q > QB'({1'b0, {(DW-1){1'b1}}})) begin
          inv[i] = {1'b0, {(DW-1){1'b1}}};
          ovf    = 1'b1;
        end else begin
          inv[i] = q[DW-1:0];
        end
      end else begin
        if (big_r[QB][i] || q > QB'({1'b1, {(DW-1){1'b0}}})) begin
          inv[i] = {1'b1, {(DW-1){1'b0}}};
          ovf    = 1'b1;
        end else begin
          inv[i] = -q[DW-1:0];
        end
      end
    end
    out_nxt.inv_r0c0 = inv[0];
    out_nxt.inv_r0c1 = inv[1];
    out_nxt.inv_r0c2 = inv[2];
    out_nxt.inv_r1c0 = inv[3];
    out_nxt.inv_r1c1 = inv[4];
    out_nxt.inv_r1c2 = inv[5];
    out_nxt.inv_r2c0 = inv[6];
    out_nxt.inv_r2c1 = inv[7];
    out_nxt.inv_r2c2 = inv[8];
    out_nxt.singular = zero_r[QB];
    out_nxt.overflow = ovf && !zero_r[QB];
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_r <= out_nxt;
    end
  end

endmodule

// File: dv/tb_matrix_inverse_3x3_unit.sv
// ----------------------------------------------------------------------------
// tb_matrix_inverse_3x3_unit
// Self-checking bench for the 3x3 fixed-point inverse. Matrices go in with
// random gaps and the result side stalls at random. The scoreboard computes
// each inverse from wide integer cofactors and compares every field in order.
// ----------------------------------------------------------------------------
module tb_matrix_inverse_3x3_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mi3_pkg::*;

  typedef logic signed [255:0] wide_t;

  class inverse_scoreboard;
    mi3_out_t pending[$];
    int       errors;
    int       n_checked;
    int       n_singular;
    int       n_overflow;

    function mi3_out_t invert(mi3_in_t m_in);
      wide_t    m[9];
      wide_t    cof[9];
      wide_t    det;
      logic [255:0] num, den, q;
      logic     neg;
      mi3_out_t r;
      logic [DW-1:0] e;
      for (int k = 0; k < 9; k++) m[k] = wide_t'($signed(m_in[287 - 32*k -: 32]));
      for (int k = 0; k < 9; k++)
        cof[k] = m[COF_SEL[k][0]] * m[COF_SEL[k][1]] - m[COF_SEL[k][2]] * m[COF_SEL[k][3]];
      det = m[0] * cof[0] + m[1] * cof[3] + m[2] * cof[6];
      r = '0;
      if (det == 0) begin
        r.singular = 1'b1;
        return r;
      end
      den = (det < 0) ? -det : det;
      for (int k = 0; k < 9; k++) begin
        neg = (cof[k] < 0) != (det < 0);
        num = ((cof[k] < 0) ? -cof[k] : cof[k]) << SH;
        q = num / den;
        if (!neg && q > 256'h7fff_ffff) begin
          e = 32'h7fff_ffff;
          r.overflow = 1'b1;
        end else if (neg && q > 256'h8000_0000) begin
          e = 32'h8000_0000;
          r.overflow = 1'b1;
        end else begin
          e = neg ? -q[31:0] : q[31:0];
        end
        r[289 - 32*k -: 32] = e;
      end
      return r;
    endfunction

    function void note_input(mi3_in_t m_in);
      pending.push_back(invert(m_in));
    endfunction

    function void check_result(mi3_out_t got);
      mi3_out_t want;
      n_checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      n_singular += want.singular;
      n_overflow += want.overflow;
      for (int k = 0; k < 9; k++)
        if (got[289 - 32*k -: 32] !== want[289 - 32*k -: 32]) begin
          $display("%0t: entry r%0dc%0d expected %h actual %h", $time, k / 3, k % 3,
                   want[289 - 32*k -: 32], got[289 - 32*k -: 32]);
          errors++;
        end
      if (got.singular !== want.singular) begin
        $display("%0t: singular expected %b actual %b", $time, want.singular, got.singular);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time, want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  localparam int LIMIT = 200000;
  localparam int N_RANDOM = 1930;
  localparam int CALM_AFTER = 1700;

  logic     clk, rst_n;
  logic     in_valid, in_ready, out_valid, out_ready;
  mi3_in_t  in_data;
  mi3_out_t out_data;
  inverse_scoreboard sb;
  int       n_sent;
  int       cycles;
  logic     held_long;

  matrix_inverse_3x3_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);

  function automatic logic [31:0] small_val(int span);
    return 32'($signed($urandom_range(2 * span, 0)) - span);
  endfunction

  function automatic mi3_in_t diag(logic [31:0] v);
    mi3_in_t m;
    m = '0;
    m.in_r0c0 = v; m.in_r1c1 = v; m.in_r2c2 = v;
    return m;
  endfunction

  task automatic send_matrix(mi3_in_t m);
    if (n_sent < CALM_AFTER && $urandom_range(3, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do @(posedge clk); while (!in_ready);
    sb.note_input(m);
    n_sent++;
  endtask

  // receiver: random stall bursts, one long hold to back up the pipeline
  initial begin
    out_ready = 1'b0;
    held_long = 1'b0;
    @(posedge rst_n);
    forever begin
      if (n_sent >= CALM_AFTER) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (!held_long && n_sent >= 300) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        for (int c = 0; c < 300; c++) @(posedge clk);
      end else if ($urandom_range(2, 0) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(5, 1)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end
    end
  end

  initial begin
    mi3_in_t m;
    int kind;
    int wait_cycles;
    sb = new();
    n_sent = 0;
    cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_matrix(diag(32'h0001_0000));          // identity
    send_matrix('0);                           // all zero, singular
    send_matrix(diag(32'h0000_0001));          // tiny det, saturates high
    send_matrix(diag(32'hffff_ffff));          // tiny negative, saturates low
    send_matrix(diag(32'h7fff_ffff));
    send_matrix(diag(32'h8000_0000));
    send_matrix(diag(32'h0002_0000));
    send_matrix(diag(32'hfffe_0000));
    send_matrix({9{32'h7fff_ffff}});           // equal rows
    send_matrix({9{32'h8000_0000}});
    m = diag(32'h0001_0000);
    m.in_r0c1 = 32'h8000_0000; m.in_r1c2 = 32'h7fff_ffff;
    send_matrix(m);
    m = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
          32'h0004_0000, 32'h0005_0000, 32'h0006_0000,
          32'h0007_0000, 32'h0008_0000, 32'h000a_0000};
    send_matrix(m);
    m.in_r2c2 = 32'h0009_0000;                 // rank two
    send_matrix(m);
    m = diag(32'h0001_0000);
    m.in_r2c2 = 32'h0000_0100;                 // one small entry, so one big inverse entry
    send_matrix(m);

    // random
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(9, 0);
      for (int k = 0; k < 9; k++)
        m[287 - 32*k -: 32] = (kind < 3) ? $urandom() : small_val(1 << 18);
      case (kind)
        3: begin
          m.in_r2c0 = m.in_r0c0; m.in_r2c1 = m.in_r0c1; m.in_r2c2 = m.in_r0c2;
        end
        4: begin
          m = diag(small_val(1 << 9));
          m.in_r0c1 = small_val(1 << 12); m.in_r1c2 = small_val(1 << 12);
        end
        5: begin
          m.in_r0c0 = m.in_r0c0 + 32'h0010_0000;
          m.in_r1c1 = m.in_r1c1 + 32'h0010_0000;
          m.in_r2c2 = m.in_r2c2 - 32'h0010_0000;
        end
        default: ;
      endcase
      send_matrix(m);
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 60) begin
      @(posedge clk);
      wait_cycles++;
    end
    $display("%0d matrices checked: %0d singular, %0d with saturated entries",
             sb.n_checked, sb.n_singular, sb.n_overflow);
    $display("input gaps, output stalls and one long output hold exercised");
    if (sb.errors == 0 && sb.n_checked == n_sent) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/mi3_pkg.sv
rtl/matrix_inverse_3x3_unit.sv
dv/tb_matrix_inverse_3x3_unit.sv
